### rtl/stlm_pkg.sv
// Shared types and constants for the sorted two-list merge block.
// Used by stlm_front, stlm_queue, stlm_back and the top level.
`default_nettype none
package stlm_pkg;

  localparam int VALUE_W = 32;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] REQ_MERGE  = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/stlm_front.sv
// Front end: accepts input requests and classifies them into commands.
// Depends on stlm_pkg; feeds stlm_queue.
`default_nettype none
module stlm_front (
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [stlm_pkg::KIND_W-1:0]           in_req_type,
  input  wire logic signed [stlm_pkg::VALUE_W-1:0]   in_load_value,
  input  wire logic                                  q_full,
  output logic                                       push,
  output stlm_pkg::cmd_t                             push_cmd
);

  logic known;

  always_comb begin
    unique case (in_req_type)
      stlm_pkg::REQ_LOAD_A: known = 1'b1;
      stlm_pkg::REQ_LOAD_B: known = 1'b1;
      stlm_pkg::REQ_MERGE:  known = 1'b1;
      default:              known = 1'b0;
    endcase
  end

  assign in_tready      = !q_full;
  // unused request code is accepted and dropped
  assign push           = in_tvalid && !q_full && known;
  assign push_cmd.kind  = in_req_type;
  assign push_cmd.value = in_load_value;

endmodule
`default_nettype wire

### rtl/stlm_queue.sv
// Short command queue between the front end and the back end.
// Depends on stlm_pkg.
`default_nettype none
module stlm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire stlm_pkg::cmd_t push_cmd,
  output logic                full,
  output logic                head_valid,
  output stlm_pkg::cmd_t      head_cmd,
  input  wire logic           pop
);

  stlm_pkg::cmd_t                  mem [stlm_pkg::QUEUE_DEPTH];
  logic [stlm_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [stlm_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [stlm_pkg::QPTR_W:0]       cnt_r;

  assign full       = cnt_r == (stlm_pkg::QPTR_W+1)'(stlm_pkg::QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_cmd   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/stlm_back.sv
// Back end: holds lists A and B, appends loads and runs the merge.
// Depends on stlm_pkg; takes commands from stlm_queue.
`default_nettype none
module stlm_back #(
  parameter int LIST_DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 q_valid,
  input  wire stlm_pkg::cmd_t                       q_cmd,
  output logic                                      pop,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic signed [stlm_pkg::VALUE_W-1:0]       out_value,
  output logic                                      out_last
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic signed [stlm_pkg::VALUE_W-1:0] a_mem [LIST_DEPTH];
  logic signed [stlm_pkg::VALUE_W-1:0] b_mem [LIST_DEPTH];

  logic                                state_r;
  logic [CNT_W-1:0]                    a_cnt_r, b_cnt_r;
  logic [CNT_W-1:0]                    ia_r, ib_r;
  logic [CNT_W-1:0]                    ia_nxt, ib_nxt;
  logic                                out_valid_r;
  logic signed [stlm_pkg::VALUE_W-1:0] out_value_r;
  logic                                out_last_r;

  logic                                a_full, b_full;
  logic                                wr_a, wr_b, start;
  logic                                step, a_has, b_has, take_a, last;
  logic signed [stlm_pkg::VALUE_W-1:0] a_head, b_head, pick;

  assign pop    = (state_r == ST_IDLE) && q_valid;
  assign a_full = a_cnt_r == CNT_W'(LIST_DEPTH);
  assign b_full = b_cnt_r == CNT_W'(LIST_DEPTH);
  assign wr_a   = pop && (q_cmd.kind == stlm_pkg::REQ_LOAD_A) && !a_full;
  assign wr_b   = pop && (q_cmd.kind == stlm_pkg::REQ_LOAD_B) && !b_full;
  assign start  = pop && (q_cmd.kind == stlm_pkg::REQ_MERGE);

  assign step   = (state_r == ST_MERGE) && (!out_valid_r || out_tready);
  assign a_has  = ia_r != a_cnt_r;
  assign b_has  = ib_r != b_cnt_r;
  assign a_head = a_mem[ia_r[IDX_W-1:0]];
  assign b_head = b_mem[ib_r[IDX_W-1:0]];
  // tie goes to B
  assign take_a = a_has && (!b_has || (a_head < b_head));
  assign pick   = take_a ? a_head : b_head;
  assign ia_nxt = ia_r + CNT_W'(take_a);
  assign ib_nxt = ib_r + CNT_W'(!take_a);
  assign last   = (ia_nxt == a_cnt_r) && (ib_nxt == b_cnt_r);

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[a_cnt_r[IDX_W-1:0]] <= q_cmd.value;
    end
    if (wr_b) begin
      b_mem[b_cnt_r[IDX_W-1:0]] <= q_cmd.value;
    end
    if (step) begin
      out_value_r <= pick;
      out_last_r  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (wr_a) begin
            a_cnt_r <= a_cnt_r + 1'b1;
          end
          if (wr_b) begin
            b_cnt_r <= b_cnt_r + 1'b1;
          end
          if (start && (a_cnt_r != '0 || b_cnt_r != '0)) begin
            state_r <= ST_MERGE;
            ia_r    <= '0;
            ib_r    <= '0;
          end
        end
        ST_MERGE: begin
          if (step) begin
            ia_r        <= ia_nxt;
            ib_r        <= ib_nxt;
            if (last) begin
              a_cnt_r <= '0;
              b_cnt_r <= '0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

### rtl/sorted_two_list_merge_top.sv
// Top level of the sorted two-list merge block.
// Depends on stlm_pkg, stlm_front, stlm_queue and stlm_back.
//
// Input channel: in_tuser carries the request code (load A, load B, merge),
// in_tdata the signed value to append. Loads into a full list are dropped,
// unknown codes are accepted and ignored.
// Result channel: out_tdata carries the merged values smallest first, B
// before A on ties; out_tlast marks the final value of a merge. A merge of
// two empty lists gives no result. Both lists are empty after a merge.
// Requests pass a four-entry command queue; the back end retires one load
// per cycle while no merge is running. A merge passes from the queue through
// the back-end state register into the output register, then emits one value
// per cycle while the receiver takes them; requests behind it wait in the queue
// and in_tready drops once the queue is full. When the receiver stalls, the
// output register holds and the merge pauses. Reset (rst_n low, synchronous)
// empties both lists, the queue and the output register.
`default_nettype none
module sorted_two_list_merge_top #(
  parameter int LIST_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] load_value
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] merged_value
  output logic             out_tlast   // last_of_run
);

  logic                                push, q_full, q_valid, pop;
  stlm_pkg::cmd_t                      push_cmd, q_cmd;
  logic signed [stlm_pkg::VALUE_W-1:0] out_value;

  stlm_front u_front (
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_req_type   (in_tuser),
    .in_load_value ($signed(in_tdata)),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  stlm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_cmd),
    .pop        (pop)
  );

  stlm_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value),
    .out_last   (out_tlast)
  );

  assign out_tdata = out_value;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("command pushed into full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("command popped from empty queue");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

### tb/sv/sorted_two_list_merge_top_test.sv
// Testbench for sorted_two_list_merge_top: loads both lists with sorted and unsorted
// values, requests merges, and checks each merged value and end flag against a predictor.
// Depends on stlm_pkg and the sorted_two_list_merge_top RTL.
module sorted_two_list_merge_top_test;

  localparam int DEPTH = 16;
  localparam int RUN_LEN_MAX = 18;
  localparam int ITEM_TARGET = 330;
  localparam int CLK_HALF = 6;
  localparam int RUN_LIMIT_CYCLES = 200000;
  localparam logic [stlm_pkg::KIND_W-1:0] REQ_UNUSED = 2'd3;
  localparam longint VAL_MAX = 64'sh7fff_ffff;
  localparam longint VAL_MIN = -64'sh8000_0000;

  typedef struct packed {
    logic signed [stlm_pkg::VALUE_W-1:0] value;
    logic                                last;
  } merged_word_t;

  class merge_tracker;
    logic signed [stlm_pkg::VALUE_W-1:0] list_a[$];
    logic signed [stlm_pkg::VALUE_W-1:0] list_b[$];
    merged_word_t                        merged_due[$];
    int                                  mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(input string what);
      $display("merge mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    function void note_request(input logic [stlm_pkg::KIND_W-1:0] kind,
                               input logic signed [stlm_pkg::VALUE_W-1:0] value);
      merged_word_t w;
      int total;
      case (kind)
        stlm_pkg::REQ_LOAD_A: if (list_a.size() < DEPTH) list_a.push_back(value);
        stlm_pkg::REQ_LOAD_B: if (list_b.size() < DEPTH) list_b.push_back(value);
        stlm_pkg::REQ_MERGE: begin
          total = list_a.size() + list_b.size();
          for (int n = 0; n < total; n++) begin
            // ties go to B
            if (list_a.size() != 0 && (list_b.size() == 0 || list_a[0] < list_b[0]))
              w.value = list_a.pop_front();
            else
              w.value = list_b.pop_front();
            w.last = (n == total - 1);
            merged_due.push_back(w);
          end
        end
        default: ;
      endcase
    endfunction

    task check_merged(input logic [stlm_pkg::VALUE_W-1:0] value, input logic last);
      merged_word_t w;
      if (merged_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h last=%b", value, last));
      end else begin
        w = merged_due.pop_front();
        if (value !== w.value)
          report_mismatch($sformatf("value %h, expected %h", value, w.value));
        if (last !== w.last)
          report_mismatch($sformatf("last %b, expected %b (value %h)", last, w.last, w.value));
      end
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [stlm_pkg::VALUE_W-1:0] in_tdata;
  logic [stlm_pkg::KIND_W-1:0]  in_tuser;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [stlm_pkg::VALUE_W-1:0] out_tdata;
  logic                         out_tlast;

  logic tx_quiet;
  logic rx_quiet;
  int   requests_sent;

  merge_tracker tracker = new();

  sorted_two_list_merge_top #(.LIST_DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_CYCLES * 2 * CLK_HALF);
    $display("[sorted_two_list_merge_top] ERROR");
    $finish;
  end

  task automatic send_request(input logic [stlm_pkg::KIND_W-1:0] kind,
                              input logic [stlm_pkg::VALUE_W-1:0] value);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.note_request(kind, value);
    if (kind != REQ_UNUSED) requests_sent++;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.merged_due.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 2, RUN_LEN_MAX)
                                       : $urandom_range(0, 8);
  endfunction

  // mostly ascending lists; narrow ranges give many ties, one style is unsorted
  function automatic void fill_list(output int vals[RUN_LEN_MAX]);
    longint v;
    int style;
    style = $urandom_range(0, 3);
    if (style == 0)
      v = longint'($urandom_range(0, 8)) - 4;
    else if ($urandom_range(0, 3) == 0)
      v = VAL_MIN;
    else
      v = longint'(int'($urandom()));
    for (int i = 0; i < RUN_LEN_MAX; i++) begin
      if (style == 3) begin
        vals[i] = int'($urandom());
      end else begin
        vals[i] = int'(v);
        case (style)
          0: v = v + $urandom_range(0, 2);
          1: v = v + $urandom_range(0, 32'h1000_0000);
          default: v = v + $urandom_range(0, 7);
        endcase
        if (v > VAL_MAX) v = VAL_MAX;
      end
    end
  endfunction

  task automatic send_merge_run();
    int a_vals[RUN_LEN_MAX];
    int b_vals[RUN_LEN_MAX];
    int na, nb, ia, ib;
    na = pick_length();
    nb = pick_length();
    fill_list(a_vals);
    fill_list(b_vals);
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 19) == 0) send_request(REQ_UNUSED, $urandom());
      if (ib == nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        send_request(stlm_pkg::REQ_LOAD_A, a_vals[ia]);
        ia++;
      end else begin
        send_request(stlm_pkg::REQ_LOAD_B, b_vals[ib]);
        ib++;
      end
    end
    send_request(stlm_pkg::REQ_MERGE, $urandom());
  endtask

  initial begin
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      int stall;
      stall = rx_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      tracker.check_merged(out_tdata, out_tlast);
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = stlm_pkg::REQ_LOAD_A;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    requests_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty merge, unused code, extremes with a tie, one-sided merges
    send_request(stlm_pkg::REQ_MERGE, 32'h0000_0000);
    send_request(REQ_UNUSED, 32'hffff_ffff);
    send_request(stlm_pkg::REQ_LOAD_A, 32'h8000_0000);
    send_request(stlm_pkg::REQ_LOAD_A, 32'h7fff_ffff);
    send_request(stlm_pkg::REQ_LOAD_B, 32'hffff_ffff);
    send_request(stlm_pkg::REQ_LOAD_B, 32'h0000_0000);
    send_request(stlm_pkg::REQ_LOAD_B, 32'h7fff_ffff);
    send_request(stlm_pkg::REQ_MERGE, 32'hffff_ffff);
    send_request(stlm_pkg::REQ_LOAD_A, 32'h0000_0005);
    send_request(stlm_pkg::REQ_LOAD_A, 32'h0000_0003);
    send_request(stlm_pkg::REQ_MERGE, 32'h0000_0000);
    send_request(stlm_pkg::REQ_LOAD_B, 32'h0000_0001);
    send_request(stlm_pkg::REQ_MERGE, 32'h0000_0000);
    send_request(stlm_pkg::REQ_MERGE, 32'h0000_0000);
    wait_for_drain();

    while (requests_sent < ITEM_TARGET) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 4))
          send_request(stlm_pkg::KIND_W'($urandom_range(0, 3)), $urandom());
      else
        send_merge_run();
      if ($urandom_range(0, 7) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.merged_due.size() == 0)
      $display("[sorted_two_list_merge_top] OK");
    else
      $display("[sorted_two_list_merge_top] ERROR");
    $finish;
  end

endmodule

### sorted_two_list_merge_top.f
rtl/stlm_pkg.sv
rtl/stlm_front.sv
rtl/stlm_queue.sv
rtl/stlm_back.sv
rtl/sorted_two_list_merge_top.sv
tb/sv/sorted_two_list_merge_top_test.sv
